// File: rtl/core/hsh_pkg.sv
// ----------------------------------------------------------------------------
// hsh_pkg
// Shared types, constants and the round function of the HalfSipHash core.
// ----------------------------------------------------------------------------
`default_nettype none

package hsh_pkg;

    // Default round counts
    localparam int COMPRESS_ROUNDS_DEF = 2;
    localparam int FINAL_ROUNDS_DEF    = 4;

    // Lane initialization constants
    localparam logic [31:0] INIT_C2 = 32'h6c796765;
    localparam logic [31:0] INIT_C3 = 32'h74656462;

    // Finalization constant xored into lane 2
    localparam logic [7:0] FINAL_XOR = 8'hff;

    // Bit position of the length byte in the length block
    localparam int LEN_POS = 24;

    // Configuration register indexes
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    // Four 32-bit lanes, element 0 is v0
    typedef logic [3:0][31:0] t_lanes;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // accept an input item, absorb its word
        logic round;     // run one round this cycle
        logic blk;       // absorb the length block
        logic pre_v2;    // xor lane 2 with the final constant before the round
        logic post_v0;   // xor lane 0 with the current word after the round
        logic out_load;  // capture the hash into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take a new hash
    } t_stat;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_COMP = 5'b00010,
        S_BLK  = 5'b00100,
        S_FIN  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

    // One SipHash-style round over the four lanes
    function automatic t_lanes hsh_round(input t_lanes v);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        t_lanes      res;
        a = v[0];
        b = v[1];
        c = v[2];
        d = v[3];
        a = a + b; b = rotl(b, 5);  b = b ^ a; a = rotl(a, 16);
        c = c + d; d = rotl(d, 8);  d = d ^ c;
        a = a + d; d = rotl(d, 7);  d = d ^ a;
        c = c + b; b = rotl(b, 13); b = b ^ c; c = rotl(c, 16);
        res[0] = a;
        res[1] = b;
        res[2] = c;
        res[3] = d;
        hsh_round = res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/hsh_ctrl.sv
// ----------------------------------------------------------------------------
// hsh_ctrl
// Sequencer for the HalfSipHash core: schedules rounds and absorb steps.
// ----------------------------------------------------------------------------
`default_nettype none

module hsh_ctrl #(
    parameter int COMPRESS_ROUNDS = hsh_pkg::COMPRESS_ROUNDS_DEF,
    parameter int FINAL_ROUNDS    = hsh_pkg::FINAL_ROUNDS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_last,
    input  wire logic          i_full,
    input  wire hsh_pkg::t_stat i_stat,
    output hsh_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import hsh_pkg::*;

    localparam int MAX_R = (COMPRESS_ROUNDS > FINAL_ROUNDS) ? COMPRESS_ROUNDS
                                                            : FINAL_ROUNDS;
    localparam int CNT_W = $clog2(MAX_R + 1);
    localparam logic [CNT_W-1:0] CR_LAST = CNT_W'(COMPRESS_ROUNDS - 1);
    localparam logic [CNT_W-1:0] FR_LAST = CNT_W'(FINAL_ROUNDS - 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    t_state           r_state,    n_state;
    logic [CNT_W-1:0] r_rnd,      n_rnd;
    logic             r_last,     n_last;
    logic             r_need_blk, n_need_blk;

    // Where to go once the compress rounds of a word are done
    function automatic t_state after_comp(input logic last, input logic need_blk);
        if (!last) begin
            after_comp = S_IDLE;
        end else if (need_blk) begin
            after_comp = S_BLK;
        end else begin
            after_comp = S_FIN;
        end
    endfunction

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_rnd      = r_rnd;
        n_last     = r_last;
        n_need_blk = r_need_blk;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.round   = 1'b1;
                    o_cmd.post_v0 = (COMPRESS_ROUNDS == 1);
                    n_last        = i_last;
                    n_need_blk    = i_last && i_full;
                    if (COMPRESS_ROUNDS == 1) begin
                        n_state = after_comp(i_last, i_last && i_full);
                        n_rnd   = '0;
                    end else begin
                        n_state = S_COMP;
                        n_rnd   = CNT_ONE;
                    end
                end
            end
            S_COMP: begin
                o_cmd.round   = 1'b1;
                o_cmd.post_v0 = (r_rnd == CR_LAST);
                if (r_rnd == CR_LAST) begin
                    n_state = after_comp(r_last, r_need_blk);
                    n_rnd   = '0;
                end else begin
                    n_rnd = r_rnd + CNT_ONE;
                end
            end
            S_BLK: begin
                o_cmd.round   = 1'b1;
                o_cmd.blk     = 1'b1;
                o_cmd.post_v0 = (COMPRESS_ROUNDS == 1);
                n_need_blk    = 1'b0;
                if (COMPRESS_ROUNDS == 1) begin
                    n_state = S_FIN;
                    n_rnd   = '0;
                end else begin
                    n_state = S_COMP;
                    n_rnd   = CNT_ONE;
                end
            end
            S_FIN: begin
                o_cmd.round  = 1'b1;
                o_cmd.pre_v2 = (r_rnd == '0);
                if (r_rnd == FR_LAST) begin
                    n_state = S_DONE;
                    n_rnd   = '0;
                end else begin
                    n_rnd = r_rnd + CNT_ONE;
                end
            end
            S_DONE: begin
                // Hold the lanes until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_rnd   = '0;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rnd      <= '0;
            r_last     <= 1'b0;
            r_need_blk <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rnd      <= n_rnd;
            r_last     <= n_last;
            r_need_blk <= n_need_blk;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/hsh_dpath.sv
// ----------------------------------------------------------------------------
// hsh_dpath
// Lanes, round unit, length counter, key registers and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsh_dpath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic [31:0]   i_word,
    input  wire logic [2:0]    i_byte_count,
    input  wire logic          i_last,
    input  wire hsh_pkg::t_cmd i_cmd,
    input  wire logic          i_stall,
    output hsh_pkg::t_stat     o_stat,
    output logic               o_valid,
    output logic [31:0]        o_hash
);
    import hsh_pkg::*;

    logic [31:0] r_key_low;
    logic [31:0] r_key_high;
    t_lanes      r_lanes,     n_lanes;
    logic [31:0] r_msg,       n_msg;
    logic [7:0]  r_len,       n_len;
    logic        r_in_msg,    n_in_msg;
    logic [31:0] r_hash;
    logic        r_out_valid;

    logic [2:0]  cnt_eff;
    logic        full_in;
    logic [7:0]  len_new;
    logic [31:0] mask;
    logic [31:0] m_in;
    logic [31:0] m_len;
    logic [31:0] m_cur;
    t_lanes      init;
    t_lanes      pre;
    t_lanes      post;

    // Decode the input item into the word to absorb
    always_comb begin
        cnt_eff = i_byte_count[2] ? 3'd4 : i_byte_count;
        full_in = !i_last || i_byte_count[2];
        len_new = (r_in_msg ? r_len : 8'd0) + (full_in ? 8'd4 : {5'd0, cnt_eff});
        case (cnt_eff[1:0])
            2'd0:    mask = 32'h0000_0000;
            2'd1:    mask = 32'h0000_00ff;
            2'd2:    mask = 32'h0000_ffff;
            2'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'h0000_0000;
        endcase
        m_in  = full_in ? i_word : ((i_word & mask) | {len_new, {LEN_POS{1'b0}}});
        m_len = {r_len, {LEN_POS{1'b0}}};
    end

    // Lane update: optional pre-xors, one round, optional post-xor
    always_comb begin
        init[0] = r_key_low;
        init[1] = r_key_high;
        init[2] = r_key_low ^ INIT_C2;
        init[3] = r_key_high ^ INIT_C3;

        pre = (i_cmd.load && !r_in_msg) ? init : r_lanes;
        if (i_cmd.load) begin
            pre[3] = pre[3] ^ m_in;
        end
        if (i_cmd.blk) begin
            pre[3] = pre[3] ^ m_len;
        end
        if (i_cmd.pre_v2) begin
            pre[2] = pre[2] ^ {24'd0, FINAL_XOR};
        end

        if (i_cmd.load) begin
            m_cur = m_in;
        end else if (i_cmd.blk) begin
            m_cur = m_len;
        end else begin
            m_cur = r_msg;
        end

        post = hsh_round(pre);
        if (i_cmd.post_v0) begin
            post[0] = post[0] ^ m_cur;
        end

        n_lanes  = i_cmd.round ? post : r_lanes;
        n_msg    = (i_cmd.load || i_cmd.blk) ? m_cur : r_msg;
        n_len    = i_cmd.load ? len_new : r_len;
        n_in_msg = i_cmd.load ? !i_last : r_in_msg;
    end

    // Message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= 8'd0;
            r_in_msg <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_in_msg <= n_in_msg;
        end
    end

    // Lanes and current word
    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
        r_msg   <= n_msg;
    end

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= 32'd0;
            r_key_high <= 32'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_KEY_LOW) begin
                r_key_low <= i_cfg_data;
            end
            if (i_cfg_index == REG_KEY_HIGH) begin
                r_key_high <= i_cfg_data;
            end
        end
    end

    // Output register: load the hash, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_hash <= r_lanes[1] ^ r_lanes[3];
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_stall;
    assign o_valid         = r_out_valid;
    assign o_hash          = r_hash;

endmodule

`default_nettype wire

// File: rtl/core/half_siphash_24_32bit.sv
// ----------------------------------------------------------------------------
// half_siphash_24_32bit
// Keyed HalfSipHash-2-4, 32-bit result, over little-endian 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key through the config port (index 0 low word, index 1 high
//   word) while the core is idle; it is sampled on the first item of each
//   message. Stream a message as items on i_valid/o_stall, each with a word,
//   a byte count and a last flag; only the last item may be short.
//   One hash comes out on o_valid/i_stall per message, after the last item.
// Sequence:
//   A single round unit runs one round per cycle, except while a finished
//   hash waits for the output register. A non-last item runs its
//   COMPRESS_ROUNDS rounds before the next item is taken. A last item runs
//   COMPRESS_ROUNDS, another COMPRESS_ROUNDS for the length block when it
//   carries four bytes, then FINAL_ROUNDS, then loads the output register.
// Reset and stall:
//   Reset clears the key, the message state and the output valid, and holds
//   the input stalled. While the receiver stalls, the hash holds in the
//   output register and the next message runs; a second hash then waits in
//   the lanes, with the input stalled, until the output register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module half_siphash_24_32bit #(
    parameter int COMPRESS_ROUNDS = hsh_pkg::COMPRESS_ROUNDS_DEF,
    parameter int FINAL_ROUNDS    = hsh_pkg::FINAL_ROUNDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_hash
);
    import hsh_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  busy;

    // Sequencer
    hsh_ctrl #(
        .COMPRESS_ROUNDS (COMPRESS_ROUNDS),
        .FINAL_ROUNDS    (FINAL_ROUNDS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .i_full  (i_byte_count[2]),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Lanes and round unit
    hsh_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_word       (i_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .i_cmd        (cmd),
        .i_stall      (i_stall),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_hash       (o_hash)
    );

    // Take a new item only between items and out of reset
    assign o_stall = busy || !i_rst_n;

endmodule

`default_nettype wire

// File: tb/tb_half_siphash_24_32bit.sv
// ----------------------------------------------------------------------------
// tb_half_siphash_24_32bit
// Self-checking bench for the HalfSipHash-2-4 core: messages go in as word
// items, a built-in hash predictor tracks the lanes and the length byte, and
// every hash that leaves the core is checked against the oldest prediction.
// Both handshakes get random gaps and stalls; the key changes between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_half_siphash_24_32bit;

    import hsh_pkg::*;

    localparam int          COMP_RNDS     = 2;
    localparam int          FIN_RNDS      = 4;
    localparam logic [31:0] LANE2_SEED    = 32'h6c796765;
    localparam logic [31:0] LANE3_SEED    = 32'h74656462;
    localparam logic [31:0] FIN_MASK      = 32'h000000ff;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        fin;
    } t_msg_item;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic        i_cfg_index  = 1'b0;
    logic [31:0] i_cfg_data   = 32'h0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [31:0] i_word       = 32'h0;
    logic [2:0]  i_byte_count = 3'd0;
    logic        i_last       = 1'b0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic [31:0] o_hash;

    // Items waiting to be sent and hashes waiting to come out
    t_msg_item   msg_items[$];
    logic [31:0] expected_hashes[$];

    // Predictor state
    logic [31:0] key_lo;
    logic [31:0] key_hi;
    logic [31:0] lanes[4];
    logic [7:0]  msg_len;
    logic        msg_open;

    int src_mode;
    int snk_mode;
    int src_wait;
    int sink_wait;
    int fail_count;
    int cycle_count;

    half_siphash_24_32bit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_word       (i_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hash       (o_hash)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mode 0: no gaps, 1: full range, 2: mostly back to back
    function automatic int draw_wait(input int mode);
        case (mode)
            0:       draw_wait = 0;
            1:       draw_wait = $urandom_range(0, 13);
            default: draw_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        endcase
    endfunction

    // One round over the four predicted lanes
    task automatic sip_round();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        a = lanes[0];
        b = lanes[1];
        c = lanes[2];
        d = lanes[3];
        a = a + b; b = {b[26:0], b[31:27]}; b = b ^ a; a = {a[15:0], a[31:16]};
        c = c + d; d = {d[23:0], d[31:24]}; d = d ^ c;
        a = a + d; d = {d[24:0], d[31:25]}; d = d ^ a;
        c = c + b; b = {b[18:0], b[31:19]}; b = b ^ c; c = {c[15:0], c[31:16]};
        lanes[0] = a;
        lanes[1] = b;
        lanes[2] = c;
        lanes[3] = d;
    endtask

    task automatic absorb_word(input logic [31:0] m);
        lanes[3] = lanes[3] ^ m;
        repeat (COMP_RNDS) sip_round();
        lanes[0] = lanes[0] ^ m;
    endtask

    // Advance the predictor by one accepted item; queue a hash on the last one
    task automatic hash_step(input logic [31:0] w, input logic [2:0] cnt_in,
                             input logic fin);
        logic [2:0]  cnt;
        logic [31:0] blk;
        cnt = (cnt_in > 3'd4) ? 3'd4 : cnt_in;
        if (!msg_open) begin
            lanes[0] = key_lo;
            lanes[1] = key_hi;
            lanes[2] = key_lo ^ LANE2_SEED;
            lanes[3] = key_hi ^ LANE3_SEED;
            msg_len  = 8'd0;
            msg_open = 1'b1;
        end
        if (!fin) begin
            absorb_word(w);
            msg_len = msg_len + 8'd4;
        end else begin
            if (cnt == 3'd4) begin
                absorb_word(w);
                msg_len = msg_len + 8'd4;
                blk     = 32'h0;
            end else begin
                msg_len = msg_len + 8'(cnt);
                blk     = w & ((32'h1 << (8 * cnt)) - 32'h1);
            end
            blk = blk | {msg_len, 24'h0};
            absorb_word(blk);
            lanes[2] = lanes[2] ^ FIN_MASK;
            repeat (FIN_RNDS) sip_round();
            expected_hashes.push_back(lanes[1] ^ lanes[3]);
            msg_open = 1'b0;
        end
    endtask

    task automatic push_item(input logic [31:0] w, input logic [2:0] cnt, input logic fin);
        t_msg_item it;
        it.word  = w;
        it.count = cnt;
        it.fin   = fin;
        msg_items.push_back(it);
    endtask

    // Mostly full words, now and then a short or oversized count on any item
    task automatic queue_random_message(input int n_words);
        int r;
        for (int k = 0; k < n_words; k++) begin
            push_item($urandom, ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                      1'b0);
        end
        r = $urandom_range(0, 11);
        push_item($urandom, (r < 10) ? 3'(r % 5) : 3'($urandom_range(5, 7)), 1'b1);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == REG_KEY_LOW)
            key_lo = val;
        else
            key_hi = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_key(input logic [31:0] lo, input logic [31:0] hi);
        write_reg(REG_KEY_LOW, lo);
        write_reg(REG_KEY_HIGH, hi);
    endtask

    // Block until everything is sent and every hash has come out, then drain;
    // look just after the edge so the driver and monitor updates have landed
    task automatic wait_core_idle();
        @(posedge i_clk);
        #1;
        while (msg_items.size() != 0 || i_valid || expected_hashes.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drive items; run the predictor on every accepted one
    always @(posedge i_clk) begin : drive_items
        t_msg_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_stall === 1'b0)
                hash_step(i_word, i_byte_count, i_last);
            if (!i_valid || o_stall === 1'b0) begin
                if (src_wait > 0) begin
                    src_wait--;
                    i_valid <= 1'b0;
                end else if (msg_items.size() != 0) begin
                    nxt          = msg_items.pop_front();
                    i_word       <= nxt.word;
                    i_byte_count <= nxt.count;
                    i_last       <= nxt.fin;
                    i_valid      <= 1'b1;
                    src_wait     = draw_wait(src_mode);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Take hashes, compare with the oldest prediction, stall at random
    always @(posedge i_clk) begin : check_hashes
        logic [31:0] want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid === 1'b1 && !i_stall) begin
                if (expected_hashes.size() == 0) begin
                    $display("%0t: unexpected hash, expected none, got %08h", $time, o_hash);
                    fail_count++;
                end else begin
                    want = expected_hashes.pop_front();
                    if (o_hash !== want) begin
                        $display("%0t: hash mismatch, expected %08h, got %08h",
                                 $time, want, o_hash);
                        fail_count++;
                    end
                end
                sink_wait = draw_wait(snk_mode);
            end else if (o_valid === 1'b1 && sink_wait > 0) begin
                sink_wait--;
            end
            i_stall <= (sink_wait != 0);
        end
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d hashes still expected", $time, expected_hashes.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int n_items;
        int n_words;
        key_lo      = 32'h0;
        key_hi      = 32'h0;
        msg_len     = 8'd0;
        msg_open    = 1'b0;
        src_mode    = 1;
        snk_mode    = 1;
        src_wait    = 0;
        sink_wait   = 0;
        fail_count  = 0;
        cycle_count = 0;
        for (int k = 0; k < 4; k++) lanes[k] = 32'h0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset key: empty message with junk in the word, then open a message
        push_item(32'hdeadbeef, 3'd0, 1'b1);
        push_item(32'h01234567, 3'd4, 1'b0);
        wait_core_idle();

        // New key while a message is open; that message keeps the old key
        write_key(32'hffffffff, 32'hffffffff);
        push_item(32'h89abcdef, 3'd2, 1'b1);
        // Full last word, then high bytes past the count ignored
        push_item(32'hffffffff, 3'd4, 1'b1);
        push_item(32'h00000000, 3'd4, 1'b0);
        push_item(32'hffffff5a, 3'd1, 1'b1);
        // Short counts on non-last items still absorb full words
        push_item(32'h11223344, 3'd2, 1'b0);
        push_item(32'h55667788, 3'd0, 1'b0);
        push_item(32'hcafef00d, 3'd3, 1'b1);
        // Oversized counts act as four bytes
        push_item(32'h0badc0de, 3'd7, 1'b1);
        push_item(32'h13579bdf, 3'd5, 1'b0);
        push_item(32'h2468ace0, 3'd6, 1'b1);
        wait_core_idle();

        write_key(32'h03020100, 32'h07060504);
        push_item(32'h03020100, 3'd4, 1'b0);
        push_item(32'h07060504, 3'd4, 1'b1);
        push_item(32'h00000000, 3'd0, 1'b1);
        push_item(32'hfedcba98, 3'd3, 1'b1);
        wait_core_idle();

        // Random phases; the fourth one forces a message of at least 256 bytes
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0:       write_key(32'h00000000, 32'h00000000);
                1:       write_key(32'hffffffff, 32'hffffffff);
                2:       write_key(32'h00000000, 32'hffffffff);
                default: write_key($urandom, $urandom);
            endcase
            src_mode = phase % 3;
            snk_mode = (phase + 1) % 3;
            n_items  = 0;
            while (n_items < 75) begin
                if ((phase == 3 && n_items == 0) || $urandom_range(0, 39) == 0)
                    n_words = $urandom_range(64, 70);
                else
                    n_words = $urandom_range(0, 8);
                queue_random_message(n_words);
                n_items += n_words + 1;
            end
            wait_core_idle();
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
